/* hdl/tcw_pkg.sv */
// Package for the text console character writer: types, codes and defaults.
`timescale 1ns / 1ps
package tcw_pkg;

	// Geometry defaults
	localparam int LINE_COLS_DEF = 80;
	localparam int LAST_ROW_DEF  = 30;
	localparam int TAB_STEP_DEF  = 12;

	// Depth of the command queue between front and back (power of two)
	localparam int QUEUE_DEPTH = 4;

	// Control bytes
	localparam logic [7:0] CHAR_BEL = 8'h07;
	localparam logic [7:0] CHAR_TAB = 8'h09;
	localparam logic [7:0] CHAR_LF  = 8'h0A;
	localparam logic [7:0] CHAR_CR  = 8'h0D;

	// Ink digit decode constants
	localparam logic [7:0] CHAR_NINE   = 8'h39;
	localparam logic [7:0] CHAR_ZERO   = 8'h30;
	localparam logic [7:0] HEX_LETTER_GAP = 8'd7;

	// Result word kinds
	typedef enum logic [1:0] {
		KIND_WRITE  = 2'd0,
		KIND_CLEAR  = 2'd1,
		KIND_SCROLL = 2'd2
	} kind_t;

	// One queued command: an optional cell write, an optional scroll pair
	typedef struct packed {
		logic       wr;
		logic       scr;
		logic [5:0] wr_row;
		logic [6:0] col;
		logic [7:0] glyph;
		logic [7:0] ink;
		logic [5:0] clr_row;
		logic [8:0] offs;
	} cmd_t;

	// Queue status seen by the front and back
	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

/* hdl/tcw_char_if.sv */
// Input channel carrying one character byte per word.
`timescale 1ns / 1ps
interface tcw_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;

	modport source (output valid, output char_code, input ready);
	modport sink   (input valid, input char_code, output ready);
endinterface

/* hdl/tcw_result_if.sv */
// Output channel carrying one screen operation per word.
`timescale 1ns / 1ps
interface tcw_result_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [5:0] row;
	logic [6:0] col;
	logic [7:0] glyph;
	logic [7:0] ink;
	logic [8:0] scroll_offset;
	logic       last;

	modport source (output valid, output kind, output row, output col, output glyph,
		output ink, output scroll_offset, output last, input ready);
	modport sink   (input valid, input kind, input row, input col, input glyph,
		input ink, input scroll_offset, input last, output ready);
endinterface

/* hdl/tcw_front.sv */
// Front end: accepts bytes, keeps cursor state and classifies each byte into a command.
`timescale 1ns / 1ps
module tcw_front #(
	parameter int LINE_COLS = tcw_pkg::LINE_COLS_DEF,
	parameter int LAST_ROW  = tcw_pkg::LAST_ROW_DEF,
	parameter int TAB_STEP  = tcw_pkg::TAB_STEP_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [6:0]        cfg_wdata,
	tcw_char_if.sink          chars,
	input  tcw_pkg::q_status_t q_stat,
	output logic              push,
	output tcw_pkg::cmd_t     push_cmd
);
	import tcw_pkg::*;

	localparam int ROW_W = $clog2(LAST_ROW + 1);

	logic [7:0]       cursor_col_q, cursor_col_n;
	logic [7:0]       tab_col_q, tab_col_n;
	logic [ROW_W-1:0] cursor_row_q, cursor_row_n;
	logic [5:0]       scroll_row_q, scroll_row_n;
	logic [7:0]       ink_color_q, ink_color_n;
	logic             ink_pending_q, ink_pending_n;
	logic [6:0]       left_margin_q;

	logic       accept;
	logic       do_lf;
	logic [7:0] col_inc;
	logic [7:0] digit;
	cmd_t       cmd;

	assign chars.ready = !q_stat.full;
	assign accept      = chars.valid && chars.ready;
	assign col_inc     = cursor_col_q + 8'd1;
	assign digit       = (chars.char_code > CHAR_NINE) ? chars.char_code - HEX_LETTER_GAP
	                                                   : chars.char_code;

	// Classify the byte and work out the next cursor state
	always_comb begin
		cursor_col_n  = cursor_col_q;
		tab_col_n     = tab_col_q;
		cursor_row_n  = cursor_row_q;
		scroll_row_n  = scroll_row_q;
		ink_color_n   = ink_color_q;
		ink_pending_n = ink_pending_q;
		do_lf         = 1'b0;
		cmd           = '0;
		if (ink_pending_q) begin
			ink_color_n   = digit - CHAR_ZERO;
			ink_pending_n = 1'b0;
		end else begin
			case (chars.char_code)
				CHAR_CR: begin
					cursor_col_n = {1'b0, left_margin_q};
					tab_col_n    = '0;
				end
				CHAR_LF: begin
					do_lf = 1'b1;
				end
				CHAR_BEL: begin
					ink_pending_n = 1'b1;
				end
				CHAR_TAB: begin
					tab_col_n    = tab_col_q + 8'(TAB_STEP);
					cursor_col_n = tab_col_q + 8'(TAB_STEP);
				end
				default: begin
					cmd.wr     = 1'b1;
					cmd.wr_row = scroll_row_q + 6'(cursor_row_q);
					cmd.col    = cursor_col_q[6:0];
					cmd.glyph  = chars.char_code;
					cmd.ink    = ink_color_q;
					cursor_col_n = col_inc;
					if (col_inc >= 8'(LINE_COLS)) begin
						cursor_col_n = {1'b0, left_margin_q};
						tab_col_n    = '0;
						do_lf        = 1'b1;
					end
				end
			endcase
		end
		// Line feed: step down, or scroll the ring at the last row
		if (do_lf) begin
			if (cursor_row_q < ROW_W'(LAST_ROW)) begin
				cursor_row_n = cursor_row_q + ROW_W'(1);
			end else begin
				scroll_row_n = scroll_row_q + 6'd1;
				cmd.scr      = 1'b1;
				cmd.clr_row  = scroll_row_q + 6'd1 + 6'(cursor_row_q);
				cmd.offs     = {scroll_row_q + 6'd1, 3'b000};
			end
		end
	end

	assign push     = accept && (cmd.wr || cmd.scr);
	assign push_cmd = cmd;

	// Hold cursor state, advance it on each accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_col_q  <= '0;
			tab_col_q     <= '0;
			cursor_row_q  <= '0;
			scroll_row_q  <= '0;
			ink_color_q   <= '0;
			ink_pending_q <= 1'b0;
		end else if (accept) begin
			cursor_col_q  <= cursor_col_n;
			tab_col_q     <= tab_col_n;
			cursor_row_q  <= cursor_row_n;
			scroll_row_q  <= scroll_row_n;
			ink_color_q   <= ink_color_n;
			ink_pending_q <= ink_pending_n;
		end
	end

	// Left margin register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_margin_q <= '0;
		end else if (cfg_we) begin
			left_margin_q <= cfg_wdata;
		end
	end

	// The cursor row never passes the last row
	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		cursor_row_q <= ROW_W'(LAST_ROW))
		else $error("cursor row beyond last row");

	// A scroll only happens from the last row and leaves the row in place
	a_scroll_row: assert property (@(posedge clk) disable iff (!arst_n)
		push && push_cmd.scr |=> cursor_row_q == ROW_W'(LAST_ROW))
		else $error("scroll issued away from last row");

endmodule

/* hdl/tcw_queue.sv */
// Short register queue of commands between front and back.
`timescale 1ns / 1ps
module tcw_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  tcw_pkg::cmd_t      push_cmd,
	input  logic               pop,
	output tcw_pkg::cmd_t      head,
	output tcw_pkg::q_status_t q_stat
);
	import tcw_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	cmd_t             entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign q_stat.full  = (count_q == CNT_W'(QUEUE_DEPTH));
	assign q_stat.empty = (count_q == '0);
	assign head         = entry_q[rd_ptr_q];

	// Store pushed commands
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	// Never push into a full queue or pop an empty one
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && q_stat.full))
		else $error("push into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && q_stat.empty))
		else $error("pop from empty queue");

endmodule

/* hdl/tcw_back.sv */
// Back end: expands each queued command into result words behind an output register.
`timescale 1ns / 1ps
module tcw_back (
	input  logic               clk,
	input  logic               arst_n,
	input  tcw_pkg::cmd_t      head,
	input  tcw_pkg::q_status_t q_stat,
	output logic               pop,
	tcw_result_if.source       results
);
	import tcw_pkg::*;

	logic [1:0] ph_q;
	logic [1:0] cnt;
	logic       load;
	logic       is_write;
	logic       is_clear;
	logic       is_last;

	kind_t      kind_c;
	logic [5:0] row_c;
	logic [6:0] col_c;
	logic [7:0] glyph_c;
	logic [7:0] ink_c;
	logic [8:0] offs_c;

	logic       valid_q;
	kind_t      kind_q;
	logic [5:0] row_q;
	logic [6:0] col_q;
	logic [7:0] glyph_q;
	logic [7:0] ink_q;
	logic [8:0] offs_q;
	logic       last_q;

	assign cnt      = {head.scr, 1'b0} + {1'b0, head.wr};
	assign is_write = head.wr && (ph_q == 2'd0);
	assign is_clear = !is_write && (head.wr ? (ph_q == 2'd1) : (ph_q == 2'd0));
	assign is_last  = (ph_q == cnt - 2'd1);
	assign load     = !q_stat.empty && (!valid_q || results.ready);
	assign pop      = load && is_last;

	// Pick the payload of the next word
	always_comb begin
		kind_c  = KIND_SCROLL;
		row_c   = '0;
		col_c   = '0;
		glyph_c = '0;
		ink_c   = '0;
		offs_c  = '0;
		if (is_write) begin
			kind_c  = KIND_WRITE;
			row_c   = head.wr_row;
			col_c   = head.col;
			glyph_c = head.glyph;
			ink_c   = head.ink;
		end else if (is_clear) begin
			kind_c = KIND_CLEAR;
			row_c  = head.clr_row;
		end else begin
			offs_c = head.offs;
		end
	end

	// Step through the words of the head command
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q    <= '0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				ph_q <= is_last ? 2'd0 : ph_q + 2'd1;
			end
			if (load) begin
				valid_q <= 1'b1;
			end else if (results.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	// Output payload register
	always_ff @(posedge clk) begin
		if (load) begin
			kind_q  <= kind_c;
			row_q   <= row_c;
			col_q   <= col_c;
			glyph_q <= glyph_c;
			ink_q   <= ink_c;
			offs_q  <= offs_c;
			last_q  <= is_last;
		end
	end

	assign results.valid         = valid_q;
	assign results.kind          = kind_q;
	assign results.row           = row_q;
	assign results.col           = col_q;
	assign results.glyph         = glyph_q;
	assign results.ink           = ink_q;
	assign results.scroll_offset = offs_q;
	assign results.last          = last_q;

	// Every queued command yields at least one word
	a_head_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		!q_stat.empty |-> (head.wr || head.scr))
		else $error("queued command without results");

	// The word index stays inside the head command
	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		!q_stat.empty |-> ph_q < cnt)
		else $error("word index past end of command");

endmodule

/* hdl/text_console_char_writer.sv */
// Top level of the text console character writer.
//
// Usage: bytes enter on the chars channel (valid/ready, one byte per word).
// Printable bytes write a glyph and ink cell at the cursor; CR, LF, TAB and
// BEL (followed by one hex ink digit) steer the cursor and ink. Screen
// operations leave on the results channel, one per word: cell write, row
// attribute clear, or vertical scroll offset; last marks an input's final word.
// left_margin is to be loaded via cfg_we/cfg_wdata only while idle (unchecked).
//
// A byte's first result word passes the queue, then the output register.
// Throughput: one byte per cycle into a four-entry command queue while not
// full; the output register drains one word per cycle unless stalled, so a
// byte's write, clear and scroll words leave in turn. Bytes with no results
// (CR, TAB, BEL, ink digits, LF above the last row) never enter the queue.
//
// Reset clears cursor, tab, row, scroll, ink, margin and the queue.
// When the receiver stalls, the output word holds, the queue fills, and
// chars.ready drops once the queue is full.
`timescale 1ns / 1ps
module text_console_char_writer #(
	parameter int LINE_COLS = tcw_pkg::LINE_COLS_DEF,
	parameter int LAST_ROW  = tcw_pkg::LAST_ROW_DEF,
	parameter int TAB_STEP  = tcw_pkg::TAB_STEP_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [6:0]   cfg_wdata,
	tcw_char_if.sink     chars,
	tcw_result_if.source results
);
	import tcw_pkg::*;

	logic      push;
	logic      pop;
	cmd_t      push_cmd;
	cmd_t      head;
	q_status_t q_stat;

	// Accept and classify bytes
	tcw_front #(
		.LINE_COLS (LINE_COLS),
		.LAST_ROW  (LAST_ROW),
		.TAB_STEP  (TAB_STEP)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.chars     (chars),
		.q_stat    (q_stat),
		.push      (push),
		.push_cmd  (push_cmd)
	);

	// Decouple front and back
	tcw_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.q_stat   (q_stat)
	);

	// Expand commands into result words
	tcw_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (head),
		.q_stat  (q_stat),
		.pop     (pop),
		.results (results)
	);

endmodule

/* verif/text_console_char_writer_checker.sv */
// Checker for the text console character writer: predicts screen operations and compares them.
`timescale 1ns / 1ps
module text_console_char_writer_checker #(
	parameter int LINE_COLS = tcw_pkg::LINE_COLS_DEF,
	parameter int LAST_ROW  = tcw_pkg::LAST_ROW_DEF,
	parameter int TAB_STEP  = tcw_pkg::TAB_STEP_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [6:0] cfg_wdata,
	tcw_char_if        chars,
	tcw_result_if      results,
	output int         fail_count,
	output int         pending,
	output int         writes_seen,
	output int         clears_seen,
	output int         scrolls_seen
);
	import tcw_pkg::*;

	localparam int MAX_REPORTS = 10;

	// One screen operation as it leaves the results channel
	typedef struct packed {
		kind_t      kind;
		logic [5:0] row;
		logic [6:0] col;
		logic [7:0] glyph;
		logic [7:0] ink;
		logic [8:0] offs;
		logic       last;
	} screen_op_t;

	screen_op_t expected_ops[$];
	screen_op_t step_ops[$];

	// Console state as the block should hold it
	logic [7:0] cursor_col;
	logic [7:0] tab_col;
	logic [5:0] cursor_row;
	logic [5:0] scroll_row;
	logic [7:0] ink_color;
	logic       ink_pending;
	logic [6:0] left_margin;
	int         word_index;

	function automatic screen_op_t make_op(kind_t kind, logic [5:0] row, logic [6:0] col,
		logic [7:0] glyph, logic [7:0] ink, logic [8:0] offs);
		screen_op_t op;
		op.kind  = kind;
		op.row   = row;
		op.col   = col;
		op.glyph = glyph;
		op.ink   = ink;
		op.offs  = offs;
		op.last  = 1'b0;
		return op;
	endfunction

	function automatic string describe(screen_op_t op);
		return $sformatf("kind=%0d row=%0d col=%0d glyph=%02h ink=%02h offs=%0d last=%0b",
			op.kind, op.row, op.col, op.glyph, op.ink, op.offs, op.last);
	endfunction

	function automatic logic [5:0] ring_row();
		return scroll_row + cursor_row;
	endfunction

	task automatic log_failure(input string what);
		fail_count++;
		if (fail_count <= MAX_REPORTS)
			$display("ERROR: %s", what);
	endtask

	task automatic return_to_margin();
		cursor_col = {1'b0, left_margin};
		tab_col    = 8'd0;
	endtask

	// Move down a row, or scroll the ring once the bottom row is reached
	task automatic advance_line();
		if (cursor_row < LAST_ROW) begin
			cursor_row = cursor_row + 6'd1;
		end else begin
			scroll_row = scroll_row + 6'd1;
			step_ops.push_back(make_op(KIND_CLEAR, ring_row(), 7'd0, 8'd0, 8'd0, 9'd0));
			step_ops.push_back(make_op(KIND_SCROLL, 6'd0, 7'd0, 8'd0, 8'd0,
				{scroll_row, 3'b000}));
		end
	endtask

	// Apply one accepted byte and queue the operations it causes
	task automatic console_step(input logic [7:0] code);
		logic [7:0] digit;
		step_ops.delete();
		if (ink_pending) begin
			digit       = (code > CHAR_NINE) ? code - HEX_LETTER_GAP : code;
			ink_color   = digit - CHAR_ZERO;
			ink_pending = 1'b0;
		end else if (code == CHAR_CR) begin
			return_to_margin();
		end else if (code == CHAR_LF) begin
			advance_line();
		end else if (code == CHAR_BEL) begin
			ink_pending = 1'b1;
		end else if (code == CHAR_TAB) begin
			tab_col    = tab_col + 8'(TAB_STEP);
			cursor_col = tab_col;
		end else begin
			step_ops.push_back(make_op(KIND_WRITE, ring_row(), cursor_col[6:0], code,
				ink_color, 9'd0));
			cursor_col = cursor_col + 8'd1;
			// wrap at the end of the line, also from a column already past it
			if (cursor_col >= LINE_COLS) begin
				return_to_margin();
				advance_line();
			end
		end
		if (step_ops.size() > 0)
			step_ops[step_ops.size() - 1].last = 1'b1;
		foreach (step_ops[i])
			expected_ops.push_back(step_ops[i]);
	endtask

	// Compare one accepted word with the oldest expectation
	task automatic check_word();
		screen_op_t want;
		screen_op_t got;
		got       = make_op(kind_t'(results.kind), results.row, results.col, results.glyph,
			results.ink, results.scroll_offset);
		got.last  = results.last;
		word_index++;
		if (expected_ops.size() == 0) begin
			log_failure($sformatf("word %0d with nothing expected: %s", word_index,
				describe(got)));
		end else begin
			want = expected_ops.pop_front();
			if (got.kind !== want.kind || got.row !== want.row || got.col !== want.col ||
				got.glyph !== want.glyph || got.ink !== want.ink ||
				got.offs !== want.offs || got.last !== want.last) begin
				log_failure($sformatf("word %0d expected %s, got %s", word_index,
					describe(want), describe(got)));
			end else begin
				case (want.kind)
					KIND_WRITE: writes_seen++;
					KIND_CLEAR: clears_seen++;
					default:    scrolls_seen++;
				endcase
			end
		end
	endtask

	// Track margin writes, retire results, then predict from the accepted byte
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_col   = 8'd0;
			tab_col      = 8'd0;
			cursor_row   = 6'd0;
			scroll_row   = 6'd0;
			ink_color    = 8'd0;
			ink_pending  = 1'b0;
			left_margin  = 7'd0;
			word_index   = 0;
			fail_count   = 0;
			pending      = 0;
			writes_seen  = 0;
			clears_seen  = 0;
			scrolls_seen = 0;
			expected_ops.delete();
		end else begin
			if (cfg_we)
				left_margin = cfg_wdata;
			if (results.valid && results.ready)
				check_word();
			if (chars.valid && chars.ready)
				console_step(chars.char_code);
			pending = expected_ops.size();
		end
	end

endmodule

/* verif/text_console_char_writer_tb.sv */
// Testbench top for the text console character writer: stimulus, idling and verdict.
`timescale 1ns / 1ps
module text_console_char_writer_tb;
	import tcw_pkg::*;

	localparam int MAX_GAP        = 12;
	localparam int RX_HOLD_CYCLES = 200;
	localparam int DRAIN_CYCLES   = 8;
	localparam int CYCLE_LIMIT    = 60000;
	localparam int PHASE_ITEMS    = 8;
	localparam int MARGIN_MAX     = 79;

	localparam logic [7:0] PRINT_LO     = 8'h20;
	localparam logic [7:0] PRINT_HI     = 8'h7E;
	localparam logic [7:0] CHAR_UPPER_A = 8'h41;
	localparam logic [7:0] CHAR_LOWER_A = 8'h61;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [6:0] cfg_wdata;

	tcw_char_if   chars_if ();
	tcw_result_if results_if ();

	int fail_count;
	int pending;
	int writes_seen;
	int clears_seen;
	int scrolls_seen;
	int bytes_sent;
	int margins_set;
	int cycle_count;
	bit tx_no_idle;
	bit tx_burst;
	bit rx_no_idle;
	bit hold_req;
	bit hold_taken;

	text_console_char_writer u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.chars     (chars_if),
		.results   (results_if)
	);

	text_console_char_writer_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.chars        (chars_if),
		.results      (results_if),
		.fail_count   (fail_count),
		.pending      (pending),
		.writes_seen  (writes_seen),
		.clears_seen  (clears_seen),
		.scrolls_seen (scrolls_seen)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Offer one byte after a random gap and hold it until the word is taken
	task automatic send_char(input logic [7:0] code);
		int gap;
		if ($urandom_range(0, 19) == 0)
			tx_no_idle = !tx_no_idle;
		gap = (tx_no_idle || tx_burst) ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			chars_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		chars_if.valid     <= 1'b1;
		chars_if.char_code <= code;
		@(posedge clk);
		while (!(chars_if.valid && chars_if.ready)) @(posedge clk);
		bytes_sent++;
	endtask

	// Stop offering and let every expected word come out
	task automatic wait_for_drain();
		chars_if.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_margin(input logic [6:0] value);
		wait_for_drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		margins_set++;
	endtask

	function automatic logic [7:0] text_byte();
		if ($urandom_range(0, 9) < 7)
			return 8'($urandom_range(PRINT_LO, PRINT_HI));
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [7:0] ink_digit();
		case ($urandom_range(0, 3))
			0:       return CHAR_ZERO + 8'($urandom_range(0, 9));
			1:       return CHAR_UPPER_A + 8'($urandom_range(0, 5));
			2:       return CHAR_LOWER_A + 8'($urandom_range(0, 5));
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// Send one short sequence: line feeds, text, tabs, ink change, CR or noise
	task automatic send_random_sequence();
		int pick;
		int len;
		pick = $urandom_range(0, 99);
		if (pick < 25) begin
			len = $urandom_range(1, 10);
			repeat (len) send_char(CHAR_LF);
		end else if (pick < 55) begin
			len = $urandom_range(1, 12);
			repeat (len) send_char(text_byte());
		end else if (pick < 65) begin
			len = $urandom_range(1, 12);
			repeat (len) send_char(CHAR_TAB);
			len = $urandom_range(1, 3);
			repeat (len) send_char(text_byte());
		end else if (pick < 75) begin
			send_char(CHAR_BEL);
			send_char(ink_digit());
		end else if (pick < 85) begin
			send_char(CHAR_CR);
			if ($urandom_range(0, 1) == 1)
				send_char(CHAR_LF);
		end else begin
			send_char(8'($urandom_range(0, 255)));
		end
	endtask

	task automatic run_random_phase(input int items);
		int target;
		target = bytes_sent + items;
		while (bytes_sent < target)
			send_random_sequence();
	endtask

	// Accept words after random gaps, with one long hold-off on request
	initial begin : result_sink
		int gap;
		results_if.ready <= 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (hold_req && !hold_taken) begin
				hold_taken = 1'b1;
				results_if.ready <= 1'b0;
				repeat (RX_HOLD_CYCLES) @(posedge clk);
				gap = 0;
			end else begin
				if ($urandom_range(0, 19) == 0)
					rx_no_idle = !rx_no_idle;
				gap = rx_no_idle ? 0 : $urandom_range(0, MAX_GAP);
			end
			if (gap > 0) begin
				results_if.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			results_if.ready <= 1'b1;
			@(posedge clk);
			while (!(results_if.valid && results_if.ready)) @(posedge clk);
		end
	end

	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("ERROR: no end of run within %0d cycles", CYCLE_LIMIT);
		$display("text_console_char_writer verification failed");
		$finish;
	end

	initial begin : stimulus
		arst_n             <= 1'b0;
		cfg_we             <= 1'b0;
		cfg_wdata          <= 7'd0;
		chars_if.valid     <= 1'b0;
		chars_if.char_code <= 8'd0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: byte extremes, ink digits of every form, tabs past the line
		write_margin(7'd0);
		send_char(CHAR_UPPER_A);
		send_char(8'h00);
		send_char(8'hFF);
		send_char(CHAR_BEL);
		send_char(CHAR_ZERO + 8'd5);
		send_char(CHAR_BEL);
		send_char(CHAR_UPPER_A + 8'd5);
		send_char(CHAR_BEL);
		send_char(CHAR_LOWER_A + 8'd5);
		send_char(CHAR_BEL);
		send_char(8'h00);
		send_char(CHAR_BEL);
		send_char(8'hFF);
		send_char(CHAR_BEL);
		send_char(CHAR_BEL);
		send_char(CHAR_LOWER_A);
		repeat (7) send_char(CHAR_TAB);
		send_char(CHAR_UPPER_A);
		send_char(CHAR_CR);
		send_char(CHAR_LF);

		// Widest margin: a byte printed at the margin wraps, and the ring scrolls soon
		write_margin(7'(MARGIN_MAX));
		run_random_phase(PHASE_ITEMS);

		// Mid margin with a long output stall while text keeps coming
		write_margin(7'($urandom_range(1, MARGIN_MAX - 1)));
		run_random_phase(10);
		hold_req = 1'b1;
		tx_burst = 1'b1;
		repeat (16) send_char(8'($urandom_range(PRINT_LO, PRINT_HI)));
		tx_burst = 1'b0;
		run_random_phase(12);

		// Zero margin with a full drain in the middle
		write_margin(7'd0);
		run_random_phase(13);
		wait_for_drain();
		run_random_phase(13);

		write_margin(7'd1);
		run_random_phase(PHASE_ITEMS);
		write_margin(7'(MARGIN_MAX));
		run_random_phase(PHASE_ITEMS);

		wait_for_drain();
		$display("Summary: %0d bytes, %0d margins, ink digits, tab runs, %0d-cycle output stall",
			bytes_sent, margins_set, RX_HOLD_CYCLES);
		$display("Summary: %0d cell writes, %0d row clears, %0d scroll offsets matched",
			writes_seen, clears_seen, scrolls_seen);
		if (fail_count == 0) begin
			$display("text_console_char_writer verification clean");
		end else begin
			$display("ERROR: %0d mismatching words", fail_count);
			$display("text_console_char_writer verification failed");
		end
		$finish;
	end

endmodule

/* files.f */
hdl/tcw_pkg.sv
hdl/tcw_char_if.sv
hdl/tcw_result_if.sv
hdl/tcw_front.sv
hdl/tcw_queue.sv
hdl/tcw_back.sv
hdl/text_console_char_writer.sv
verif/text_console_char_writer_checker.sv
verif/text_console_char_writer_tb.sv
